/* hdl/eni_pkg.sv */
// eni_pkg: shared widths, opcodes and divider handshake types
// for the envelope node interpolator; no dependencies
`timescale 1ns / 1ps

package eni_pkg;

	localparam int DEF_MAX_NODES = 25;

	localparam int TICK_W  = 16;
	localparam int VAL_W   = 8;
	localparam int IDX_W   = 5;
	localparam int COUNT_W = 5;
	localparam int NODE_W  = TICK_W + VAL_W;
	localparam int PROD_W  = TICK_W + VAL_W;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [TICK_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* hdl/eni_ram.sv */
// eni_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module eni_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 25,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/eni_div.sv */
// eni_div: iterative restoring divider, one quotient bit per cycle
// depends on eni_pkg (widths, div_req_t, div_rsp_t)
`timescale 1ns / 1ps

module eni_div
	import eni_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(PROD_W);

	typedef enum logic {
		D_IDLE,
		D_RUN
	} div_state_t;

	div_state_t        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TICK_W-1:0] rem_q;
	logic [TICK_W-1:0] den_q;
	logic [PROD_W-1:0] quo_q;
	logic              done_q;

	logic [TICK_W:0]   trial;
	logic              fits;
	logic [TICK_W-1:0] rem_nx;

	// shift in next dividend bit and try the subtraction
	always_comb begin
		trial  = {rem_q, quo_q[PROD_W-1]};
		fits   = trial >= {1'b0, den_q};
		rem_nx = fits ? TICK_W'(trial - {1'b0, den_q}) : trial[TICK_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			rem_q   <= '0;
			den_q   <= '0;
			quo_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						rem_q   <= '0;
						den_q   <= req.divisor;
						quo_q   <= req.dividend;
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= rem_nx;
					quo_q <= {quo_q[PROD_W-2:0], fits};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(PROD_W - 1)) begin
						state_q <= D_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(state_q == D_RUN))
		else $error("divider done without a run");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == D_RUN |-> !req.start)
		else $error("divider started while running");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == D_RUN |-> rem_q < den_q)
		else $error("partial remainder not below divisor");

endmodule

/* hdl/envelope_node_interpolator_unit.sv */
// envelope_node_interpolator_unit: top level, node table, scan sequencer,
// shared multiply and divide; depends on eni_pkg, eni_ram, eni_div
`timescale 1ns / 1ps

// channel  | direction | handshake                    | word
// ---------+-----------+------------------------------+----------------------------------
// command  | in        | start high and busy low      | opcode, node_index, node_tick,
//          |           |                              | node_value, current_tick
// result   | out       | done strobe, one cycle       | envelope_value
// config   | in        | cfg_valid and cfg_ready high | cfg_data (node count)
//
// a write word gives no result; busy stays low
// an evaluate word reads up to n nodes (1 <= n <= MAX_NODES), each one through
// the registered ram port in S_RD then S_CMP: a direct hit gives that node's value,
// an interpolation adds the multiply and the bit-serial divider
// busy is high from accept until the result strobe; reset clears the sequencer and
// the node count, the table itself holds rubbish until written
// the receiver cannot stall: done is a single-cycle strobe
module envelope_node_interpolator_unit
	import eni_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic [IDX_W-1:0]   node_index,
	input  logic [TICK_W-1:0]  node_tick,
	input  logic [VAL_W-1:0]   node_value,
	input  logic [TICK_W-1:0]  current_tick,
	output logic               done,
	output logic [VAL_W-1:0]   envelope_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [COUNT_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_NODES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_MUL,
		S_DGO,
		S_DIV
	} seq_state_t;

	seq_state_t         state_q;
	logic [COUNT_W-1:0] node_count_q;
	logic [AW-1:0]      pt_q;
	logic [AW-1:0]      limit_q;
	logic [TICK_W-1:0]  tick_q;
	logic [TICK_W-1:0]  prev_tick_q;
	logic [VAL_W-1:0]   prev_val_q;
	logic [TICK_W-1:0]  dt_q;
	logic [TICK_W-1:0]  span_q;
	logic [VAL_W-1:0]   mag_q;
	logic               neg_q;
	logic [PROD_W-1:0]  prod_q;
	logic               done_q;
	logic [VAL_W-1:0]   result_q;

	logic               accept;
	logic               wr_en;
	logic [AW-1:0]      limit_d;
	logic [NODE_W-1:0]  rd_data;
	logic [TICK_W-1:0]  rd_tick;
	logic [VAL_W-1:0]   rd_val;
	logic [VAL_W:0]     dv;
	logic [VAL_W-1:0]   q8;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	// configuration: always ready; writes must only arrive while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// a node write goes straight into the table; out-of-range indices are dropped
	assign wr_en = accept && (opcode == OP_WRITE) && (32'(node_index) < MAX_NODES);

	// last node the scan may land on: count of zero acts as one, large counts saturate
	always_comb begin
		if (node_count_q == '0) begin
			limit_d = '0;
		end else if (32'(node_count_q) > MAX_NODES) begin
			limit_d = AW'(MAX_NODES - 1);
		end else begin
			limit_d = AW'(node_count_q - 1'b1);
		end
	end

	eni_ram #(
		.WIDTH (NODE_W),
		.DEPTH (MAX_NODES)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(node_index)),
		.wdata ({node_tick, node_value}),
		.re    (state_q == S_RD),
		.raddr (pt_q),
		.rdata (rd_data)
	);

	assign rd_tick = rd_data[NODE_W-1:VAL_W];
	assign rd_val  = rd_data[VAL_W-1:0];

	// signed value step of the segment in two's complement, later kept as sign and magnitude
	assign dv = {1'b0, rd_val} - {1'b0, prev_val_q};

	assign div_req.start    = (state_q == S_DGO);
	assign div_req.dividend = prod_q;
	assign div_req.divisor  = span_q;

	eni_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// only the low byte of the quotient reaches the wrapped result
	assign q8 = div_rsp.quotient[VAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= 1'b0;
			pt_q        <= '0;
			limit_q     <= '0;
			tick_q      <= '0;
			prev_tick_q <= '0;
			prev_val_q  <= '0;
			dt_q        <= '0;
			span_q      <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			prod_q      <= '0;
			result_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && (opcode == OP_EVAL)) begin
						tick_q      <= current_tick;
						limit_q     <= limit_d;
						pt_q        <= '0;
						// the segment before node 0 starts at tick 0, value 0
						prev_tick_q <= '0;
						prev_val_q  <= '0;
						state_q     <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if ((pt_q < limit_q) && (tick_q > rd_tick)) begin
						// not there yet: this node becomes the segment start
						prev_tick_q <= rd_tick;
						prev_val_q  <= rd_val;
						pt_q        <= pt_q + 1'b1;
						state_q     <= S_RD;
					end else if (tick_q >= rd_tick) begin
						result_q <= rd_val;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if ((rd_tick > prev_tick_q) && (tick_q > prev_tick_q)) begin
						dt_q    <= tick_q - prev_tick_q;
						span_q  <= rd_tick - prev_tick_q;
						neg_q   <= dv[VAL_W];
						mag_q   <= dv[VAL_W] ? VAL_W'(-dv) : dv[VAL_W-1:0];
						state_q <= S_MUL;
					end else begin
						// degenerate segment: hold the start value
						result_q <= prev_val_q;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_MUL: begin
					prod_q  <= {{VAL_W{1'b0}}, dt_q} * {{TICK_W{1'b0}}, mag_q};
					state_q <= S_DGO;
				end
				S_DGO: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						// truncation toward zero: divide the magnitude, then apply the sign
						result_q <= neg_q ? (prev_val_q - q8) : (prev_val_q + q8);
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign envelope_value = result_q;

	a_done_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an evaluation in flight");

	a_div_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && div_rsp.done |=> done && !busy)
		else $error("divider result not delivered");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> pt_q <= limit_q)
		else $error("node scan ran past the node count");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> (pt_q == '0) && (state_q == S_RD))
		else $error("scan did not start at node zero");

	a_div_span: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> span_q != '0)
		else $error("divide by a zero-length segment");

endmodule
